FILE: design/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
// No dependencies; imported by the channel interfaces and the top level.
package mlr_pkg;

  localparam int unsigned COORD_BITS = 11;
  localparam int unsigned DELTA_BITS = COORD_BITS + 1;
  localparam int unsigned DEC_BITS   = COORD_BITS + 3;
  // one guard bit above the decision width for the step sum
  localparam int unsigned WIDE_BITS  = COORD_BITS + 4;

  typedef logic        [COORD_BITS-1:0] coord_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;

  localparam dec_t DEC_MAX = {1'b0, {(DEC_BITS-1){1'b1}}};
  localparam dec_t DEC_MIN = {1'b1, {(DEC_BITS-1){1'b0}}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

endpackage

FILE: design/mlr_in_if.sv
// Request channel of the line rasterizer: valid/ready plus one request item.
// Depends on mlr_pkg.
interface mlr_in_if import mlr_pkg::*; ();
  logic   valid;
  logic   ready;
  op_e    op;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

FILE: design/mlr_out_if.sv
// Pixel channel of the line rasterizer: valid/ready plus one pixel item.
// Depends on mlr_pkg.
interface mlr_out_if import mlr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   pixel_valid;
  logic   is_last;

  modport source (output valid, pixel_x, pixel_y, pixel_valid, is_last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_valid, is_last, output ready);
endinterface

FILE: design/midpoint_line_rasterizer_unit.sv
// Midpoint line rasterizer, top level. Depends on mlr_pkg, mlr_in_if, mlr_out_if.
// The result item sits in the output register from the cycle after accept.
// Throughput: one item per cycle unless stalled; the path is one add, a saturate and a
// coordinate compare from the line state registers into the output register.
// Reset (rst_ni low, async): no line active, all line state zero, output empty.
module midpoint_line_rasterizer_unit import mlr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mlr_in_if.sink    in_i,
  mlr_out_if.source out_o
);

  // Line state
  coord_t cur_x_q, cur_x_d;
  coord_t cur_y_q, cur_y_d;
  coord_t major_end_q, major_end_d;
  delta_t delta_x_q, delta_x_d;
  delta_t delta_y_q, delta_y_d;
  dec_t   decision_q, decision_d;
  logic   y_major_q, y_major_d;
  logic   active_q, active_d;

  // Output register
  logic   out_valid_q;
  coord_t pix_x_q, pix_x_d;
  coord_t pix_y_q, pix_y_d;
  logic   pix_valid_q, pix_valid_d;
  logic   is_last_q, is_last_d;

  logic   accept;

  // Load-path values
  delta_t ld_dx, ld_dy, ld_major_d, ld_minor_d, ld_half;
  logic   ld_y_major;
  wide_t  ld_sum;
  // Step-path values
  delta_t st_major_d, st_minor_d;
  wide_t  st_sum;
  coord_t major_now;

  function automatic dec_t sat_dec(wide_t v);
    if (v > wide_t'(DEC_MAX)) begin
      return DEC_MAX;
    end else if (v < wide_t'(DEC_MIN)) begin
      return DEC_MIN;
    end
    return dec_t'(v);
  endfunction

  // The output register frees up when its item is taken, so a new item
  // can enter in the same cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Load: deltas from the endpoints, pick the major axis.
  assign ld_dx      = $signed({1'b0, in_i.end_x}) - $signed({1'b0, in_i.start_x});
  assign ld_dy      = $signed({1'b0, in_i.end_y}) - $signed({1'b0, in_i.start_y});
  assign ld_y_major = ld_dy > ld_dx;
  assign ld_major_d = ld_y_major ? ld_dy : ld_dx;
  assign ld_minor_d = ld_y_major ? ld_dx : ld_dy;
  // halve toward zero: bias negative values by one before the shift
  assign ld_half    = (ld_major_d
                       + $signed({{(DELTA_BITS-1){1'b0}}, ld_major_d[DELTA_BITS-1]})) >>> 1;
  assign ld_sum     = wide_t'(ld_minor_d) - wide_t'(ld_half);

  // Step: decision update in the guard width, saturated afterwards.
  assign st_major_d = y_major_q ? delta_y_q : delta_x_q;
  assign st_minor_d = y_major_q ? delta_x_q : delta_y_q;
  assign st_sum     = decision_q[DEC_BITS-1]
                      ? wide_t'(decision_q) + wide_t'(st_minor_d)
                      : wide_t'(decision_q) + wide_t'(st_minor_d) - wide_t'(st_major_d);

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    major_end_d = major_end_q;
    delta_x_d   = delta_x_q;
    delta_y_d   = delta_y_q;
    decision_d  = decision_q;
    y_major_d   = y_major_q;
    active_d    = active_q;
    pix_x_d     = '0;
    pix_y_d     = '0;
    pix_valid_d = 1'b0;
    is_last_d   = 1'b0;
    major_now   = '0;

    case (in_i.op)
      OP_LOAD: begin
        cur_x_d     = in_i.start_x;
        cur_y_d     = in_i.start_y;
        delta_x_d   = ld_dx;
        delta_y_d   = ld_dy;
        y_major_d   = ld_y_major;
        decision_d  = sat_dec(ld_sum);
        major_end_d = ld_y_major ? in_i.end_y : in_i.end_x;
        major_now   = ld_y_major ? in_i.start_y : in_i.start_x;
        // degenerate line (major end not past start): start pixel only
        is_last_d   = !(major_now < major_end_d);
        active_d    = !is_last_d;
        pix_x_d     = cur_x_d;
        pix_y_d     = cur_y_d;
        pix_valid_d = 1'b1;
      end
      OP_STEP: begin
        // with no active line the item comes back empty, state untouched
        if (active_q) begin
          decision_d = sat_dec(st_sum);
          if (y_major_q) begin
            cur_y_d = cur_y_q + coord_t'(1);
            if (!decision_q[DEC_BITS-1]) begin
              cur_x_d = cur_x_q + coord_t'(1);
            end
            major_now = cur_y_d;
          end else begin
            cur_x_d = cur_x_q + coord_t'(1);
            if (!decision_q[DEC_BITS-1]) begin
              cur_y_d = cur_y_q + coord_t'(1);
            end
            major_now = cur_x_d;
          end
          is_last_d   = !(major_now < major_end_q);
          active_d    = !is_last_d;
          pix_x_d     = cur_x_d;
          pix_y_d     = cur_y_d;
          pix_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      major_end_q <= '0;
      delta_x_q   <= '0;
      delta_y_q   <= '0;
      decision_q  <= '0;
      y_major_q   <= 1'b0;
      active_q    <= 1'b0;
    end else if (accept) begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      major_end_q <= major_end_d;
      delta_x_q   <= delta_x_d;
      delta_y_q   <= delta_y_d;
      decision_q  <= decision_d;
      y_major_q   <= y_major_d;
      active_q    <= active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_x_q     <= pix_x_d;
      pix_y_q     <= pix_y_d;
      pix_valid_q <= pix_valid_d;
      is_last_q   <= is_last_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_x     = pix_x_q;
  assign out_o.pixel_y     = pix_y_q;
  assign out_o.pixel_valid = pix_valid_q;
  assign out_o.is_last     = is_last_q;

endmodule
